[design/ship_rrip_stream_dueling_replacement_core_defines.svh]
// Assertion macros for the replacement core.
// Used by the top level; no other dependencies.
`ifndef SHIP_RRIP_STREAM_DUELING_REPLACEMENT_CORE_DEFINES_SVH
`define SHIP_RRIP_STREAM_DUELING_REPLACEMENT_CORE_DEFINES_SVH
// implication checked at every edge outside reset
`define SRD_ASSERT_IMP(label, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("check failed");
// next-cycle implication
`define SRD_ASSERT_NXT(label, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("check failed");
`endif

[design/srd_pkg.sv]
// Package for the replacement core: sizes, constants, helper types.
// No dependencies.
`default_nettype none
package srd_pkg;
  localparam int NUM_SETS = 2048;
  localparam int NUM_WAYS = 16;
  localparam int SIGNATURE_BITS = 6;
  localparam int LEADER_COUNT = 64;
  localparam int SEL_BITS = 10;
  localparam int ADDR_BITS = 48;
  localparam int LIMIT_BITS = 21;
  localparam int SET_BITS = $clog2(NUM_SETS);
  localparam int WAY_BITS = 4;
  localparam int SIG_ENTRIES = 1 << SIGNATURE_BITS;
  localparam int AGE_ROW_BITS = 2 * NUM_WAYS;
  localparam int SIGROW_BITS = SIGNATURE_BITS * NUM_WAYS;
  localparam int STRM_BITS = ADDR_BITS + ADDR_BITS + 1 + 1;
  localparam logic [SEL_BITS-1:0] SEL_MID = SEL_BITS'(1 << (SEL_BITS - 1));
  localparam logic [SEL_BITS-1:0] SEL_MAX = SEL_BITS'((1 << SEL_BITS) - 1);
  localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = LIMIT_BITS'(512 * 1024);
  localparam logic OP_VICTIM = 1'b0;
  localparam logic OP_UPDATE = 1'b1;
endpackage
`default_nettype wire

[design/srd_if.sv]
// Valid/ready channel interfaces for the replacement core.
// Depends on srd_pkg.
`default_nettype none
interface srd_in_if import srd_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic                      operation;
  logic [10:0]               set_index;
  logic [3:0]                way_index;
  logic                      hit;
  logic [ADDR_BITS-1:0]      address;
  logic [SIGNATURE_BITS-1:0] pc_signature;
  modport source (output valid, operation, set_index, way_index, hit, address,
                  pc_signature, input ready);
  modport sink (input valid, operation, set_index, way_index, hit, address,
                pc_signature, output ready);
endinterface

interface srd_out_if import srd_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [3:0]          victim_way;
  logic                streaming;
  logic [SEL_BITS-1:0] selector_value;
  modport source (output valid, victim_way, streaming, selector_value, input ready);
  modport sink (input valid, victim_way, streaming, selector_value, output ready);
endinterface
`default_nettype wire

[design/srd_ram.sv]
// Generic single-port-write, one-read synchronous RAM, registered read.
// No dependencies.
`default_nettype none
module srd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

[design/ship_rrip_stream_dueling_replacement_core.sv]
// Top level of the replacement core: sequencer, set memories, policy logic.
// Depends on srd_pkg, srd_if, srd_ram and the defines header.
//
//  channel  dir  handshake      payload
//  in       in   valid/ready    operation set_index way_index hit address pc_signature
//  out      out  valid/ready    victim_way streaming selector_value
//  cfg      in   write enable   stream_stride_limit
//
// An item passes through the states idle, read and write before the next input transfer:
// read the set rows, modify them and read the reuse counter, write back.
// The result is registered in the read state, into the output register when it is free.
// After reset a clearing pass walks the 2048 set rows, one a cycle, before the first
// transfer. A stalled result holds the output register; one more result waits in a
// skid register, and the input stalls while that one is full.
`default_nettype none
`include "ship_rrip_stream_dueling_replacement_core_defines.svh"
module ship_rrip_stream_dueling_replacement_core import srd_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  srd_in_if.sink                     in_ch,
  srd_out_if.source                  out_ch,
  input  wire logic                  cfg_we,
  input  wire logic [LIMIT_BITS-1:0] cfg_wdata
);
  typedef enum logic [3:0] {
    ST_CLEAR = 4'b0001, ST_IDLE = 4'b0010, ST_READ = 4'b0100, ST_WRITE = 4'b1000
  } state_t;
  typedef struct packed {
    logic                      op;
    logic [SET_BITS-1:0]       set;
    logic [WAY_BITS-1:0]       way;
    logic                      hit;
    logic [ADDR_BITS-1:0]      addr;
    logic [SIGNATURE_BITS-1:0] sig;
  } item_t;

  state_t state_r, state_nxt;
  item_t item_r;
  logic [SET_BITS:0] clr_r;
  logic [LIMIT_BITS-1:0] limit_r;
  logic [SEL_BITS-1:0] sel_r, sel_nxt;
  logic out_valid_r;
  logic [3:0] out_way_r;
  logic out_strm_r;
  logic [SEL_BITS-1:0] out_sel_r;
  logic pend_valid_r;
  logic [3:0] pend_way_r;
  logic pend_strm_r;
  logic [SEL_BITS-1:0] pend_sel_r;
  logic out_free;

  logic [AGE_ROW_BITS-1:0] age_rd, age_wd;
  logic [SIGROW_BITS-1:0] sig_rd, sig_wd;
  logic [STRM_BITS-1:0] strm_rd, strm_wd;
  logic we;
  logic [SET_BITS-1:0] waddr, raddr;
  logic clearing;

  logic [1:0] reuse_rd, reuse_wd;
  logic reuse_we;
  logic [SIGNATURE_BITS-1:0] reuse_waddr, reuse_raddr, bs_r;
  logic ins_strm_r, ins_sig_r;

  assign clearing = (state_r == ST_CLEAR);
  assign out_free = !out_valid_r || out_ch.ready;
  assign in_ch.ready = (state_r == ST_IDLE) && !pend_valid_r;
  assign raddr = in_ch.set_index[SET_BITS-1:0];
  assign waddr = clearing ? clr_r[SET_BITS-1:0] : item_r.set;
  assign we = clearing || (state_r == ST_WRITE);

  srd_ram #(.WIDTH(AGE_ROW_BITS), .DEPTH(NUM_SETS)) u_age (
    .clk, .we, .waddr, .wdata(age_wd), .raddr, .rdata(age_rd));
  srd_ram #(.WIDTH(SIGROW_BITS), .DEPTH(NUM_SETS)) u_sig (
    .clk, .we, .waddr, .wdata(sig_wd), .raddr, .rdata(sig_rd));
  srd_ram #(.WIDTH(STRM_BITS), .DEPTH(NUM_SETS)) u_strm (
    .clk, .we, .waddr, .wdata(strm_wd), .raddr, .rdata(strm_rd));
  srd_ram #(.WIDTH(2), .DEPTH(SIG_ENTRIES)) u_reuse (
    .clk, .we(reuse_we), .waddr(reuse_waddr), .wdata(reuse_wd), .raddr(reuse_raddr),
    .rdata(reuse_rd));

  // modify stage, registered into the write state
  logic [AGE_ROW_BITS-1:0] age_m_r, age_m, age_fix;
  logic [SIGROW_BITS-1:0] sig_m_r, sig_m;
  logic [STRM_BITS-1:0] strm_m_r, strm_m;
  logic [3:0] vic;
  logic flag;
  logic [1:0] top, add;
  logic [ADDR_BITS-1:0] paddr, pstride_mag;
  logic pneg;
  logic [ADDR_BITS:0] stride;
  logic [ADDR_BITS-1:0] mag;
  logic lead_sig, lead_str, use_sig, use_str;
  logic [1:0] c, ins;
  logic [SIGNATURE_BITS-1:0] bs;

  assign lead_sig = item_r.set < SET_BITS'(LEADER_COUNT);
  assign lead_str = item_r.set >= SET_BITS'(NUM_SETS - LEADER_COUNT);
  assign use_sig = lead_sig || (!lead_str && sel_r >= SEL_MID);
  assign use_str = lead_str || (!lead_sig && sel_r < SEL_MID);

  // stream row: {flag, stride sign, stride magnitude, previous address}
  always_comb begin
    age_m = age_rd;
    sig_m = sig_rd;
    strm_m = strm_rd;
    vic = '0;
    top = '0;
    paddr = strm_rd[ADDR_BITS-1:0];
    pstride_mag = strm_rd[2*ADDR_BITS-1:ADDR_BITS];
    pneg = strm_rd[2*ADDR_BITS];
    flag = strm_rd[STRM_BITS-1];
    stride = {1'b0, item_r.addr} - {1'b0, paddr};
    mag = stride[ADDR_BITS] ? ADDR_BITS'(-stride) : stride[ADDR_BITS-1:0];
    bs = '0;
    for (int w = 0; w < NUM_WAYS; w++)
      if (age_rd[2*w +: 2] > top) top = age_rd[2*w +: 2];
    add = 2'd3 - top;
    if (item_r.op == OP_VICTIM) begin
      for (int w = 0; w < NUM_WAYS; w++) age_m[2*w +: 2] = age_rd[2*w +: 2] + add;
      for (int w = NUM_WAYS - 1; w >= 0; w--)
        if (age_m[2*w +: 2] == 2'd3) vic = WAY_BITS'(w);
    end else begin
      flag = ((pstride_mag != '0) || pneg) && (mag == pstride_mag) &&
             ({27'd0, mag} < {{(ADDR_BITS + 27 - LIMIT_BITS){1'b0}}, limit_r});
      strm_m = {flag, stride[ADDR_BITS], mag, item_r.addr};
      bs = sig_rd[SIGNATURE_BITS*item_r.way +: SIGNATURE_BITS];
      if (item_r.hit) age_m[2*item_r.way +: 2] = 2'd0;
      else sig_m[SIGNATURE_BITS*item_r.way +: SIGNATURE_BITS] = item_r.sig;
    end
  end

  // reuse counter: block signature on a hit, new signature on a fill
  assign reuse_raddr = (item_r.op == OP_UPDATE && item_r.hit) ? bs : item_r.sig;
  assign reuse_we = clearing || (state_r == ST_WRITE && item_r.op == OP_UPDATE &&
                                 item_r.hit && reuse_rd != 2'd3);
  assign reuse_waddr = clearing ? clr_r[SIGNATURE_BITS-1:0] : bs_r;
  assign reuse_wd = clearing ? 2'd1 : reuse_rd + 2'd1;

  // insertion age of a fill, settled once the counter read returns
  always_comb begin
    c = reuse_rd;
    ins = 2'd2;
    if (ins_strm_r) ins = 2'd3;
    else if (ins_sig_r) ins = (c == 2'd3) ? 2'd0 : ((c == 2'd2) ? 2'd1 : 2'd3);
    age_fix = age_m_r;
    if (item_r.op == OP_UPDATE && !item_r.hit) age_fix[2*item_r.way +: 2] = ins;
  end

  always_comb begin
    sel_nxt = sel_r;
    if (item_r.op == OP_UPDATE && item_r.hit) begin
      if (lead_sig && sel_r != SEL_MAX) sel_nxt = sel_r + 1'b1;
      else if (lead_str && sel_r != '0) sel_nxt = sel_r - 1'b1;
    end
  end

  assign age_wd = clearing ? '1 : age_fix;
  assign sig_wd = clearing ? '0 : sig_m_r;
  assign strm_wd = clearing ? '0 : strm_m_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: if (clr_r == (SET_BITS+1)'(NUM_SETS - 1)) state_nxt = ST_IDLE;
      ST_IDLE:  if (in_ch.valid && in_ch.ready) state_nxt = ST_READ;
      ST_READ:  state_nxt = ST_WRITE;
      ST_WRITE: state_nxt = ST_IDLE;
      default:  state_nxt = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      clr_r <= '0;
      limit_r <= LIMIT_RESET;
      sel_r <= SEL_MID;
      out_valid_r <= 1'b0;
      pend_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (clearing) clr_r <= clr_r + 1'b1;
      if (cfg_we) limit_r <= cfg_wdata;
      if (state_r == ST_READ) begin
        sel_r <= sel_nxt;
        if (out_free) out_valid_r <= 1'b1;
        else pend_valid_r <= 1'b1;
      end else if (out_free && pend_valid_r) begin
        out_valid_r <= 1'b1;
        pend_valid_r <= 1'b0;
      end else if (out_valid_r && out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready)
      item_r <= '{in_ch.operation, in_ch.set_index[SET_BITS-1:0], in_ch.way_index,
                  in_ch.hit, in_ch.address, in_ch.pc_signature};
    if (state_r == ST_READ) begin
      age_m_r <= age_m;
      sig_m_r <= sig_m;
      strm_m_r <= strm_m;
      bs_r <= bs;
      ins_strm_r <= flag && use_str;
      ins_sig_r <= use_sig;
      if (out_free) begin
        out_way_r <= vic;
        out_strm_r <= flag;
        out_sel_r <= sel_nxt;
      end else begin
        pend_way_r <= vic;
        pend_strm_r <= flag;
        pend_sel_r <= sel_nxt;
      end
    end else if (out_free && pend_valid_r) begin
      out_way_r <= pend_way_r;
      out_strm_r <= pend_strm_r;
      out_sel_r <= pend_sel_r;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.victim_way = out_way_r;
  assign out_ch.streaming = out_strm_r;
  assign out_ch.selector_value = out_sel_r;

  `SRD_ASSERT_IMP(a_no_accept_busy, state_r != ST_IDLE, !in_ch.ready)
  `SRD_ASSERT_NXT(a_read_then_write, state_r == ST_READ, state_r == ST_WRITE && out_valid_r)
  `SRD_ASSERT_NXT(a_accept_reads, in_ch.valid && in_ch.ready, state_r == ST_READ)
  `SRD_ASSERT_IMP(a_skid_free_at_read, state_r == ST_READ, !pend_valid_r)
endmodule
`default_nettype wire

[verif/tb_ship_rrip_stream_dueling_replacement_core.sv]
// Testbench for the SHiP/RRIP replacement core: a queue-fed driver, a monitor
// and a model of victim choice, stream detection and set dueling.
// Depends on srd_pkg, srd_if and the core.
`timescale 1ns / 1ps
`default_nettype none
module tb_ship_rrip_stream_dueling_replacement_core;
  import srd_pkg::*;

  typedef struct packed {
    logic                      operation;
    logic [10:0]               set_index;
    logic [3:0]                way_index;
    logic                      hit;
    logic [ADDR_BITS-1:0]      address;
    logic [SIGNATURE_BITS-1:0] pc_signature;
  } access_t;

  typedef struct packed {
    logic [3:0]          victim_way;
    logic                streaming;
    logic [SEL_BITS-1:0] selector_value;
  } decision_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [LIMIT_BITS-1:0] cfg_wdata;

  srd_in_if  in_ch ();
  srd_out_if out_ch ();

  ship_rrip_stream_dueling_replacement_core dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  // model state
  logic [1:0]                m_age [NUM_SETS][NUM_WAYS];
  logic [SIGNATURE_BITS-1:0] m_sig [NUM_SETS][NUM_WAYS];
  logic [1:0]                m_reuse [SIG_ENTRIES];
  logic [ADDR_BITS-1:0]      m_prev_addr [NUM_SETS];
  logic [ADDR_BITS:0]        m_prev_stride [NUM_SETS];
  logic                      m_stream [NUM_SETS];
  logic [SEL_BITS-1:0]       m_psel;
  logic [LIMIT_BITS-1:0]     m_limit;

  access_t   pending_accesses [$];
  decision_t expected_decisions [$];
  int unsigned fail_count = 0;
  int unsigned cycle_count = 0;

  function automatic logic [ADDR_BITS:0] stride_mag(logic [ADDR_BITS:0] v);
    return v[ADDR_BITS] ? -v : v;
  endfunction

  task automatic model_reset();
    for (int s = 0; s < NUM_SETS; s++) begin
      for (int w = 0; w < NUM_WAYS; w++) begin
        m_age[s][w] = 2'd3;
        m_sig[s][w] = '0;
      end
      m_prev_addr[s] = '0;
      m_prev_stride[s] = '0;
      m_stream[s] = 1'b0;
    end
    for (int i = 0; i < SIG_ENTRIES; i++) m_reuse[i] = 2'd1;
    m_psel = SEL_MID;
    m_limit = LIMIT_RESET;
  endtask

  function automatic decision_t predict_decision(access_t a);
    decision_t d;
    int s;
    logic [1:0] top;
    logic lead_sig, lead_str, use_sig, use_str;
    logic [ADDR_BITS:0] stride, mag;
    logic [SIGNATURE_BITS-1:0] bs;
    s = a.set_index;
    d = '0;
    lead_sig = s < LEADER_COUNT;
    lead_str = s >= NUM_SETS - LEADER_COUNT;
    if (a.operation == OP_VICTIM) begin
      top = '0;
      for (int w = 0; w < NUM_WAYS; w++) if (m_age[s][w] > top) top = m_age[s][w];
      if (top < 2'd3)
        for (int w = 0; w < NUM_WAYS; w++) m_age[s][w] = m_age[s][w] + (2'd3 - top);
      for (int w = NUM_WAYS - 1; w >= 0; w--)
        if (m_age[s][w] == 2'd3) d.victim_way = 4'(w);
    end else begin
      stride = {1'b0, a.address} - {1'b0, m_prev_addr[s]};
      mag = stride_mag(stride);
      m_stream[s] = (m_prev_stride[s] != 0) && (mag == stride_mag(m_prev_stride[s])) &&
                    (mag < m_limit);
      m_prev_stride[s] = stride;
      m_prev_addr[s] = a.address;
      if (a.hit) begin
        bs = m_sig[s][a.way_index];
        m_age[s][a.way_index] = 2'd0;
        if (m_reuse[bs] < 2'd3) m_reuse[bs]++;
      end else begin
        use_sig = lead_sig || (!lead_str && m_psel >= SEL_MID);
        use_str = lead_str || (!lead_sig && m_psel < SEL_MID);
        m_sig[s][a.way_index] = a.pc_signature;
        if (m_stream[s] && use_str) m_age[s][a.way_index] = 2'd3;
        else if (use_sig)
          case (m_reuse[a.pc_signature])
            2'd3: m_age[s][a.way_index] = 2'd0;
            2'd2: m_age[s][a.way_index] = 2'd1;
            default: m_age[s][a.way_index] = 2'd3;
          endcase
        else m_age[s][a.way_index] = 2'd2;
      end
      if (a.hit && lead_sig && m_psel < SEL_MAX) m_psel++;
      if (a.hit && lead_str && m_psel > 0) m_psel--;
    end
    d.streaming = m_stream[s];
    d.selector_value = m_psel;
    return d;
  endfunction

  // driver
  int unsigned send_gap;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      send_gap <= 0;
    end else if (in_ch.valid && !in_ch.ready) begin
      // hold
    end else if (send_gap != 0) begin
      in_ch.valid <= 1'b0;
      send_gap <= send_gap - 1;
    end else if (pending_accesses.size() != 0) begin
      access_t a;
      a = pending_accesses.pop_front();
      in_ch.valid <= 1'b1;
      {in_ch.operation, in_ch.set_index, in_ch.way_index, in_ch.hit, in_ch.address,
       in_ch.pc_signature} <= a;
      expected_decisions.push_back(predict_decision(a));
      send_gap <= (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11));
    end else begin
      in_ch.valid <= 1'b0;
    end
  end

  // monitor
  int unsigned recv_gap;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      recv_gap <= 0;
    end else begin
      int unsigned gap_v;
      gap_v = recv_gap;
      if (out_ch.valid && out_ch.ready) begin
        decision_t e;
        if (expected_decisions.size() == 0) begin
          $error("unexpected result");
          fail_count++;
        end else begin
          e = expected_decisions.pop_front();
          if (out_ch.victim_way !== e.victim_way) begin
            $error("victim_way exp %0d got %0d", e.victim_way, out_ch.victim_way);
            fail_count++;
          end
          if (out_ch.streaming !== e.streaming) begin
            $error("streaming exp %0d got %0d", e.streaming, out_ch.streaming);
            fail_count++;
          end
          if (out_ch.selector_value !== e.selector_value) begin
            $error("selector_value exp %0d got %0d", e.selector_value,
                   out_ch.selector_value);
            fail_count++;
          end
        end
        gap_v = (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11));
      end
      if (gap_v != 0) begin
        out_ch.ready <= 1'b0;
        recv_gap <= gap_v - 1;
      end else begin
        out_ch.ready <= 1'b1;
        recv_gap <= 0;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 400000) begin
      $display("simulation failed");
      $finish;
    end
  end

  function automatic access_t rand_access(bit well_formed, int set_hint);
    access_t a;
    a.operation = 1'($urandom_range(0, 1));
    a.set_index = 11'($urandom_range(0, 2047));
    if (well_formed) a.set_index = 11'(set_hint);
    a.way_index = 4'($urandom_range(0, 15));
    a.hit = 1'($urandom_range(0, 1));
    a.address = ADDR_BITS'({$urandom, $urandom});
    a.pc_signature = SIGNATURE_BITS'($urandom_range(0, 63));
    return a;
  endfunction

  task automatic wait_drained();
    while (pending_accesses.size() != 0 || expected_decisions.size() != 0 || in_ch.valid)
      @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_limit(logic [LIMIT_BITS-1:0] v);
    cfg_wdata <= v;
    cfg_we <= 1'b1;
    @(posedge clk);
    cfg_we <= 1'b0;
    m_limit = v;
    @(posedge clk);
  endtask

  // stride stream: walk in one set by a fixed step, each address above or below the base, with fills and hits
  task automatic push_stream(int s, logic [ADDR_BITS-1:0] base, logic [ADDR_BITS-1:0] step,
                             int n);
    access_t a;
    for (int i = 0; i < n; i++) begin
      a = rand_access(1, s);
      a.operation = OP_UPDATE;
      a.address = base + step * ADDR_BITS'(i);
      if ($urandom_range(0, 1)) a.address = base - step * ADDR_BITS'(i);
      pending_accesses.push_back(a);
      if ($urandom_range(0, 2) == 0) begin
        a.operation = OP_VICTIM;
        pending_accesses.push_back(a);
      end
    end
  endtask

  initial begin
    access_t a;
    int s;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    model_reset();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: extremes, both operations, leaders, aging, negative strides
    a = '0; a.operation = OP_VICTIM; pending_accesses.push_back(a);
    a.set_index = 11'd2047; pending_accesses.push_back(a);
    a = '1; a.operation = OP_UPDATE; a.hit = 1'b1; pending_accesses.push_back(a);
    a.hit = 1'b0; pending_accesses.push_back(a);
    a.operation = OP_VICTIM; pending_accesses.push_back(a);
    for (int i = 0; i < 4; i++) begin
      a = '0; a.operation = OP_UPDATE; a.set_index = 11'd5;
      a.address = 48'h1000 - ADDR_BITS'(64 * i);
      a.way_index = 4'(i); a.hit = i[0]; a.pc_signature = 6'h3f;
      pending_accesses.push_back(a);
    end
    a = '0; a.set_index = 11'd5; pending_accesses.push_back(a);
    for (int w = 0; w < NUM_WAYS; w++) begin
      a = '0; a.operation = OP_UPDATE; a.set_index = 11'd9; a.way_index = 4'(w);
      a.hit = 1'b1;
      pending_accesses.push_back(a);
    end
    a = '0; a.set_index = 11'd9; pending_accesses.push_back(a);
    wait_drained();

    // push selector upward through signature-leader hits
    write_limit('0);
    for (int i = 0; i < 40; i++) begin
      a = rand_access(1, $urandom_range(0, LEADER_COUNT - 1));
      a.operation = OP_UPDATE; a.hit = 1'b1;
      pending_accesses.push_back(a);
    end
    wait_drained();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: write_limit('1);
        1: write_limit(LIMIT_BITS'(64));
        2: write_limit(LIMIT_BITS'(1 << 20));
        default: write_limit(LIMIT_BITS'($urandom_range(0, 2097151)));
      endcase
      for (int k = 0; k < 25; k++) begin
        s = $urandom_range(0, 2) == 0 ? $urandom_range(0, LEADER_COUNT - 1) :
            ($urandom_range(0, 1) ? $urandom_range(NUM_SETS - LEADER_COUNT, NUM_SETS - 1)
                                  : $urandom_range(0, 2047));
        if ($urandom_range(0, 3) == 0) begin
          pending_accesses.push_back(rand_access(0, 0));
        end else begin
          push_stream(s, ADDR_BITS'({$urandom, $urandom}),
                      $urandom_range(0, 1) ? ADDR_BITS'($urandom_range(1, 4096))
                                           : ADDR_BITS'({$urandom, $urandom}),
                      $urandom_range(2, 10));
        end
      end
      for (int k = 0; k < 40; k++) begin
        a = rand_access(1, NUM_SETS - 1 - $urandom_range(0, LEADER_COUNT - 1));
        a.operation = OP_UPDATE; a.hit = 1'b1;
        pending_accesses.push_back(a);
      end
      wait_drained();
    end

    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
`default_nettype wire
